@@ rtl/core/hofp_pkg.sv @@
// Shared types and constants for the ASCII octal/hex number field parser.
// No dependencies.
package hofp_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned ValueOutW = 64;

  localparam logic [CharW-1:0] CharZero  = 8'h30;  // '0'
  localparam logic [CharW-1:0] CharSeven = 8'h37;  // '7'
  localparam logic [CharW-1:0] CharNine  = 8'h39;  // '9'
  localparam logic [CharW-1:0] CharUA    = 8'h41;  // 'A'
  localparam logic [CharW-1:0] CharUF    = 8'h46;  // 'F'
  localparam logic [CharW-1:0] CharLA    = 8'h61;  // 'a'
  localparam logic [CharW-1:0] CharLF    = 8'h66;  // 'f'
  localparam logic [CharW-1:0] CharBlank = 8'h20;  // ' '
  localparam logic [CharW-1:0] TenOffset = 8'd10;

  // phase codes
  localparam logic [1:0] PhSkip   = 2'd0;
  localparam logic [1:0] PhDigits = 2'd1;
  localparam logic [1:0] PhFrozen = 2'd2;

  typedef struct packed {
    logic              is_digit;  // valid digit in the current mode
    logic              is_skip;   // blank or '0'
    logic [DigitW-1:0] value;
  } digit_t;

endpackage

@@ rtl/core/hofp_digit_dec.sv @@
// Character classifier: digit value and skip flag for one byte.
// Depends on hofp_pkg.
module hofp_digit_dec
  import hofp_pkg::*;
(
  input  logic [CharW-1:0] char_code_i,
  input  logic             hex_mode_i,
  output digit_t           digit_o
);

  logic is_oct, is_dec, is_upper, is_lower;

  assign is_oct   = (char_code_i >= CharZero) && (char_code_i <= CharSeven);
  assign is_dec   = (char_code_i >= CharZero) && (char_code_i <= CharNine);
  assign is_upper = (char_code_i >= CharUA) && (char_code_i <= CharUF);
  assign is_lower = (char_code_i >= CharLA) && (char_code_i <= CharLF);

  always_comb begin
    digit_o.is_skip  = (char_code_i == CharBlank) || (char_code_i == CharZero);
    digit_o.is_digit = is_oct || (hex_mode_i && (is_dec || is_upper || is_lower));
    if (is_upper) begin
      digit_o.value = DigitW'(char_code_i - CharUA + TenOffset);
    end else if (is_lower) begin
      digit_o.value = DigitW'(char_code_i - CharLA + TenOffset);
    end else begin
      digit_o.value = char_code_i[DigitW-1:0];  // '0'..'9' map to low nibble
    end
  end

endmodule

@@ rtl/core/hofp_step.sv @@
// Accumulator and phase state: one step per consumed byte, a shift-and-add for each digit taken.
// Depends on hofp_pkg.
module hofp_step
  import hofp_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  logic                   field_end_i,
  input  logic                   hex_mode_i,
  input  digit_t                 digit_i,
  output logic [VALUE_WIDTH-1:0] result_o
);

  logic [VALUE_WIDTH-1:0] acc_q, acc_d, acc_t, acc_shift;
  logic [1:0]             phase_q, phase_d, phase_t;
  logic                   take;

  assign acc_shift = hex_mode_i ? (acc_q << 4) : (acc_q << 3);

  always_comb begin
    unique case (phase_q)
      PhSkip:   take = !digit_i.is_skip;
      PhDigits: take = 1'b1;
      default:  take = 1'b0;  // frozen, and the unused code
    endcase
    acc_t   = acc_q;
    phase_t = phase_q;
    if (take) begin
      if (digit_i.is_digit) begin
        acc_t   = acc_shift + VALUE_WIDTH'(digit_i.value);
        phase_t = PhDigits;
      end else begin
        phase_t = PhFrozen;
      end
    end
  end

  assign result_o = acc_t;

  always_comb begin
    acc_d   = acc_q;
    phase_d = phase_q;
    if (fire_i) begin
      if (field_end_i) begin
        acc_d   = '0;
        phase_d = PhSkip;
      end else begin
        acc_d   = acc_t;
        phase_d = phase_t;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      phase_q <= PhSkip;
    end else begin
      acc_q   <= acc_d;
      phase_q <= phase_d;
    end
  end

endmodule

@@ rtl/core/hofp_out_reg.sv @@
// Result register with valid/stall handshake toward the consumer.
// Depends on hofp_pkg.
module hofp_out_reg
  import hofp_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   can_load_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [ValueOutW-1:0]   value_o
);

  logic                   valid_q, valid_d;
  logic [VALUE_WIDTH-1:0] value_q;

  assign can_load_o = !valid_q || !out_stall_i;
  assign valid_d    = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      value_q <= value_i;
    end
  end

  assign out_valid_o = valid_q;
  assign value_o     = ValueOutW'(value_q);

endmodule

@@ rtl/core/ascii_hex_octal_field_parser.sv @@
// Top level of the ASCII octal/hex number field parser.
// Depends on hofp_pkg, hofp_digit_dec, hofp_step, hofp_out_reg.
//
// Takes one field byte per cycle and returns the binary value one word per
// field, on the byte flagged as the field end. A byte lands in an input
// register; from there it is classified and folded into the accumulator
// (shift by 3 or 4 and add), and a field end loads the result register
// that holds the output word. Throughput is one byte per cycle, limited by
// the single accumulator update per cycle; input stall rises only while a
// field-end byte waits for a stalled result register. hex_mode is written
// through the cfg port (always ready) and must only change while no word is
// in flight. value bits at and above VALUE_WIDTH read as zero.
module ascii_hex_octal_field_parser
  import hofp_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 hex_mode_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CharW-1:0]     char_code_i,
  input  logic                 field_end_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ValueOutW-1:0] value_o
);

  logic                   hex_mode_q;
  logic                   s1_valid_q, s1_valid_d;
  logic [CharW-1:0]       s1_char_q;
  logic                   s1_end_q;
  logic                   s1_consume, in_fire, can_load;
  digit_t                 digit;
  logic [VALUE_WIDTH-1:0] step_result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hex_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      hex_mode_q <= hex_mode_i;
    end
  end

  // non-end bytes never wait on the result register
  assign s1_consume = s1_valid_q && (!s1_end_q || can_load);
  assign in_stall_o = s1_valid_q && !s1_consume;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_fire || (s1_valid_q && !s1_consume);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_char_q <= char_code_i;
      s1_end_q  <= field_end_i;
    end
  end

  hofp_digit_dec u_dec (
    .char_code_i (s1_char_q),
    .hex_mode_i  (hex_mode_q),
    .digit_o     (digit)
  );

  hofp_step #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (s1_consume),
    .field_end_i (s1_end_q),
    .hex_mode_i  (hex_mode_q),
    .digit_i     (digit),
    .result_o    (step_result)
  );

  hofp_out_reg #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_consume && s1_end_q),
    .value_i     (step_result),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o)
  );

`ifndef SYNTHESIS
  a_end_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_consume && s1_end_q) |=> out_valid_o)
    else $error("field end did not produce a word");

  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_end_q && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked field end");

  a_upper_bits_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((value_o >> VALUE_WIDTH) == '0))
    else $error("value bits above VALUE_WIDTH set");

  a_end_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && s1_valid_q && s1_end_q) |-> !s1_consume)
    else $error("pending word overwritten");
`endif

endmodule

@@ sim/hofp_field_checker.sv @@
// Scoreboard for the ASCII octal/hex number field parser: tracks hex_mode writes,
// folds each accepted byte into its own accumulator and checks every output word.
// Depends on hofp_pkg.
module hofp_field_checker
  import hofp_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic                 hex_mode_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [CharW-1:0]     char_code_i,
  input  logic                 field_end_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [ValueOutW-1:0] value_i,
  output int unsigned          waiting_o,
  output int unsigned          mismatch_count_o
);

  localparam logic [ValueOutW-1:0] ValueMask =
      (VALUE_WIDTH >= ValueOutW) ? ~64'd0 : ((64'd1 << VALUE_WIDTH) - 64'd1);

  logic [ValueOutW-1:0] field_values[$];
  logic                 radix_hex;
  logic [ValueOutW-1:0] acc;
  logic [1:0]           phase;
  int unsigned          mismatches;

  function automatic logic digit_of(input logic [CharW-1:0] c, input logic hex,
                                    output logic [DigitW-1:0] d);
    d = '0;
    if (c >= CharZero && c <= CharSeven) d = DigitW'(c - CharZero);
    else if (hex && c >= CharZero && c <= CharNine) d = DigitW'(c - CharZero);
    else if (hex && c >= CharUA && c <= CharUF) d = DigitW'(c - CharUA + TenOffset);
    else if (hex && c >= CharLA && c <= CharLF) d = DigitW'(c - CharLA + TenOffset);
    else return 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [DigitW-1:0]    d;
    logic [ValueOutW-1:0] want;
    if (!rst_ni) begin
      radix_hex = 1'b0;
      acc = '0;
      phase = PhSkip;
      mismatches = 0;
      field_values.delete();
    end else begin
      // a word leaving now is older than any byte taken at this edge
      if (out_valid_i && !out_stall_i) begin
        if (field_values.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("checker: word %h with no field pending", value_i);
        end else begin
          want = field_values.pop_front();
          if (value_i !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("checker: value mismatch, expected %h, got %h", want, value_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) radix_hex = hex_mode_i;
      if (in_valid_i && !in_stall_i) begin
        // blanks and zeros are skipped only before the first digit
        if ((phase == PhSkip && char_code_i != CharBlank && char_code_i != CharZero) ||
            phase == PhDigits) begin
          if (digit_of(char_code_i, radix_hex, d)) begin
            acc = (acc << (radix_hex ? 4 : 3)) + ValueOutW'(d);
            phase = PhDigits;
          end else begin
            phase = PhFrozen;
          end
        end
        if (field_end_i) begin
          field_values.push_back(acc & ValueMask);
          acc = '0;
          phase = PhSkip;
        end
      end
    end
    waiting_o <= field_values.size();
    mismatch_count_o <= mismatches;
  end

endmodule

@@ sim/ascii_hex_octal_field_parser_test.sv @@
// Testbench top for ascii_hex_octal_field_parser: drives header field bytes and
// hex_mode writes, stalls the output side at random. Depends on hofp_pkg,
// hofp_field_checker and the parser RTL.
module ascii_hex_octal_field_parser_test;
  import hofp_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold   = 80;
  localparam int unsigned PhaseBytes = 90;

  typedef logic [CharW-1:0] char_q_t[$];

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic                 hex_mode;
  logic                 in_valid;
  logic                 in_stall;
  logic [CharW-1:0]     char_code;
  logic                 field_end;
  logic                 out_valid;
  logic                 out_stall;
  logic [ValueOutW-1:0] value;
  int unsigned          waiting;
  int unsigned          mismatch_count;
  int unsigned          cycle;
  int unsigned          hold_req;
  bit                   steady;

  ascii_hex_octal_field_parser dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .hex_mode_i (hex_mode),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .char_code_i(char_code),
    .field_end_i(field_end),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .value_o    (value)
  );

  hofp_field_checker value_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .hex_mode_i      (hex_mode),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .char_code_i     (char_code),
    .field_end_i     (field_end),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .value_i         (value),
    .waiting_o       (waiting),
    .mismatch_count_o(mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // output side: random stalls, plus one long hold-off per request
  initial begin : receiver
    int unsigned run;
    int unsigned holds_served;
    holds_served = 0;
    forever begin
      if (hold_req != holds_served) begin
        holds_served = hold_req;
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
      end else begin
        run = pick_gap();
        out_stall <= (run > 0);
        repeat (run > 0 ? run : $urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [CharW-1:0] c, input logic is_end);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    field_end <= is_end;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], close && i == s.len() - 1);
  endtask

  // drain, let the pipeline settle, then write hex_mode
  task automatic set_radix(input logic hex);
    in_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    hex_mode  <= hex;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic char_q_t make_field(input logic hex);
    char_q_t     f;
    string       hex_digits;
    string       odd_digits;
    int unsigned r;
    int unsigned ndig;
    hex_digits = "0123456789ABCDEFabcdef";
    odd_digits = "89aA";
    r = $urandom_range(0, 9);
    if (r < 2) begin
      // noise
      repeat ($urandom_range(1, 12)) f.push_back(CharW'($urandom_range(0, 255)));
      return f;
    end
    repeat ($urandom_range(0, 3)) f.push_back($urandom_range(0, 1) ? CharBlank : CharZero);
    ndig = (r == 2) ? $urandom_range(17, 24) : $urandom_range(1, 11);
    repeat (ndig) begin
      if (hex) f.push_back(hex_digits[$urandom_range(0, 21)]);
      else if ($urandom_range(0, 9) == 0) f.push_back(odd_digits[$urandom_range(0, 3)]);
      else f.push_back(CharW'(CharZero + $urandom_range(0, 7)));
    end
    if ($urandom_range(0, 1)) begin
      // terminator, then whatever trails it in the header
      f.push_back($urandom_range(0, 1) ? CharBlank : 8'h00);
      repeat ($urandom_range(0, 3)) f.push_back(CharW'($urandom_range(0, 255)));
    end
    return f;
  endfunction

  initial begin : stimulus
    char_q_t     f;
    int unsigned sent;
    cfg_valid = 1'b0;
    hex_mode  = 1'b0;
    in_valid  = 1'b0;
    char_code = '0;
    field_end = 1'b0;
    steady    = 1'b0;
    hold_req  = 0;
    rst_n     = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // octal from reset
    send_text(" 0755", 1'b0);
    send_byte(8'h00, 1'b1);
    send_text("8", 1'b1);       // bad byte while still skipping
    send_text(" 0", 1'b1);      // nothing but blanks and zeros
    send_text("1 7", 1'b1);     // blank after a digit freezes
    send_byte(8'hFF, 1'b1);
    // radix switched in the middle of a field
    send_text("12", 1'b0);
    set_radix(1'b1);
    send_text("fA", 1'b1);
    send_text("89Fa@", 1'b1);

    for (int p = 0; p < 5; p++) begin
      set_radix(p[0]);
      hold_req <= hold_req + 1;
      sent = 0;
      while (sent < PhaseBytes) begin
        f = make_field(p[0]);
        steady = ($urandom_range(0, 3) == 0);
        foreach (f[i]) send_byte(f[i], i == f.size() - 1);
        sent += f.size();
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
